@@ sv/sme_pkg.sv @@
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types, codes and widths of the small matrix engine.
// ----------------------------------------------------------------------------
package sme_pkg;

	localparam int DIM_DEFAULT = 8;

	localparam int CFG_W     = 4;
	localparam int REG_IDX_W = 2;
	localparam int CMD_W     = 3;
	localparam int ELEM_W    = 3;
	localparam int VAL_W     = 32;
	localparam int DATA_W    = 40;
	localparam int Q_DEPTH   = 4;

	localparam logic [REG_IDX_W-1:0] REG_ROWS_A = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_COLS_A = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ROWS_B = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_COLS_B = 2'd3;

	localparam logic [CMD_W-1:0] CMD_LOAD_A = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_B = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ADD    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SUB    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_TR_A   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_TR_B   = 3'd5;
	localparam logic [CMD_W-1:0] CMD_MUL    = 3'd6;

	typedef enum logic [2:0] {
		K_LOAD_A,
		K_LOAD_B,
		K_ADD,
		K_SUB,
		K_TR_A,
		K_TR_B,
		K_MUL,
		K_ERR
	} kind_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	typedef struct packed {
		kind_t              kind;
		logic [ELEM_W-1:0]  row;
		logic [ELEM_W-1:0]  col;
		logic [VAL_W-1:0]   value;
		logic [CFG_W-1:0]   nr;
		logic [CFG_W-1:0]   nc;
		logic [CFG_W-1:0]   nk;
	} q_entry_t;

endpackage

@@ sv/sme_fifo.sv @@
// ----------------------------------------------------------------------------
// sme_fifo
// Short command queue between the front end and the execution back end.
// ----------------------------------------------------------------------------
module sme_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sme_pkg::q_entry_t push_data,
	output logic              full,
	input  logic              pop,
	output sme_pkg::q_entry_t pop_data,
	output logic              empty
);
	import sme_pkg::*;

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

	q_entry_t           entries_q [Q_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     cnt_q;

	assign full     = (cnt_q == (PTR_W+1)'(Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ sv/sme_front.sv @@
// ----------------------------------------------------------------------------
// sme_front
// Shape registers, command intake and classification into queue entries.
// ----------------------------------------------------------------------------
module sme_front #(
	parameter int DIM = sme_pkg::DIM_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [sme_pkg::CMD_W-1:0]      s_tuser,   // command
	input  logic [sme_pkg::DATA_W-1:0]     s_tdata,   // row, col, value
	input  logic                           cfg_we,
	input  logic [sme_pkg::REG_IDX_W-1:0]  cfg_addr,
	input  logic [sme_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           fifo_full,
	output logic                           push,
	output sme_pkg::q_entry_t              push_data
);
	import sme_pkg::*;

	logic [CFG_W-1:0]  rows_a_q, cols_a_q, rows_b_q, cols_b_q;
	logic [CFG_W-1:0]  ra, ca, rb, cb;
	logic [ELEM_W-1:0] in_row, in_col;
	logic [VAL_W-1:0]  in_value;
	logic              keep;
	logic              in_range;

	function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] r;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (32'(v) > DIM) begin
			r = CFG_W'(DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= CFG_W'(8);
			cols_a_q <= CFG_W'(8);
			rows_b_q <= CFG_W'(8);
			cols_b_q <= CFG_W'(8);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ROWS_A: rows_a_q <= cfg_wdata;
				REG_COLS_A: cols_a_q <= cfg_wdata;
				REG_ROWS_B: rows_b_q <= cfg_wdata;
				REG_COLS_B: cols_b_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign ra = eff_dim(rows_a_q);
	assign ca = eff_dim(cols_a_q);
	assign rb = eff_dim(rows_b_q);
	assign cb = eff_dim(cols_b_q);

	assign in_row   = s_tdata[ELEM_W-1:0];
	assign in_col   = s_tdata[2*ELEM_W-1:ELEM_W];
	assign in_value = s_tdata[2*ELEM_W+VAL_W-1:2*ELEM_W];
	assign in_range = (32'(in_row) < DIM) && (32'(in_col) < DIM);

	always_comb begin
		keep            = 1'b1;
		push_data.row   = in_row;
		push_data.col   = in_col;
		push_data.value = in_value;
		push_data.kind  = K_ERR;
		push_data.nr    = ra;
		push_data.nc    = ca;
		push_data.nk    = CFG_W'(1);
		unique case (s_tuser) inside
			CMD_LOAD_A, CMD_LOAD_B: begin
				keep           = in_range;
				push_data.kind = (s_tuser == CMD_LOAD_A) ? K_LOAD_A : K_LOAD_B;
			end
			CMD_ADD, CMD_SUB: begin
				if (ra == rb && ca == cb) begin
					push_data.kind = (s_tuser == CMD_ADD) ? K_ADD : K_SUB;
				end
			end
			CMD_TR_A: begin
				push_data.kind = K_TR_A;
				push_data.nr   = ca;
				push_data.nc   = ra;
			end
			CMD_TR_B: begin
				push_data.kind = K_TR_B;
				push_data.nr   = cb;
				push_data.nc   = rb;
			end
			CMD_MUL: begin
				if (ca == rb) begin
					push_data.kind = K_MUL;
				end
				push_data.nr = ra;
				push_data.nc = cb;
				push_data.nk = ca;
			end
			default: keep = 1'b0;
		endcase
	end

	assign s_tready = !fifo_full;
	assign push     = s_tvalid && !fifo_full && keep;

endmodule

@@ sv/sme_back.sv @@
// ----------------------------------------------------------------------------
// sme_back
// Matrix stores, element sequencer, read/compute pipeline and output register.
// ----------------------------------------------------------------------------
module sme_back #(
	parameter int DIM = sme_pkg::DIM_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       empty,
	input  sme_pkg::q_entry_t          head,
	output logic                       pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [sme_pkg::DATA_W-1:0] m_tdata,   // out_row, out_col, out_value
	output logic                       m_tuser,   // status
	output logic                       m_tlast    // last
);
	import sme_pkg::*;

	localparam int IW    = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int AW    = (DIM > 1) ? $clog2(DIM * DIM) : 1;
	localparam int CNT_W = CFG_W + 1;
	localparam int PAD_W = DATA_W - 2 * ELEM_W - VAL_W;

	typedef struct packed {
		kind_t             kind;
		logic              err;
		logic              first_k;
		logic              last_k;
		logic              last_el;
		logic [ELEM_W-1:0] row;
		logic [ELEM_W-1:0] col;
	} tag_t;

	logic [VAL_W-1:0] mem_a [DIM * DIM];
	logic [VAL_W-1:0] mem_b [DIM * DIM];

	seq_state_t        state_q, state_d;
	kind_t             kind_q;
	logic [CFG_W-1:0]  nr_q, nc_q, nk_q;
	logic [IW-1:0]     i_q, j_q, k_q;

	logic              adv;
	logic              start, issue, err_issue, wr_a, wr_b;
	logic              last_i, last_j, last_k;
	logic [AW-1:0]     addr_a, addr_b, waddr;

	logic              valid_s1, valid_s2;
	tag_t              tag_s1, tag_s2, tag_issue;
	logic [VAL_W-1:0]  rda_s1, rdb_s1, res_s2;
	logic [VAL_W-1:0]  acc_q, sum;

	logic              out_valid_q;
	logic [ELEM_W-1:0] out_row_q, out_col_q;
	logic [VAL_W-1:0]  out_value_q;
	logic              out_status_q, out_last_q;

	function automatic logic [AW-1:0] elem_addr(input logic [AW-1:0] r, input logic [AW-1:0] c);
		return AW'(r * AW'(DIM) + c);
	endfunction

	assign adv = !out_valid_q || m_tready;

	assign last_i = (CNT_W'(i_q) + CNT_W'(1)) == CNT_W'(nr_q);
	assign last_j = (CNT_W'(j_q) + CNT_W'(1)) == CNT_W'(nc_q);
	assign last_k = (CNT_W'(k_q) + CNT_W'(1)) == CNT_W'(nk_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		start     = 1'b0;
		issue     = 1'b0;
		err_issue = 1'b0;
		wr_a      = 1'b0;
		wr_b      = 1'b0;
		unique case (state_q)
			SEQ_IDLE: begin
				if (!empty) begin
					unique case (head.kind) inside
						K_LOAD_A: begin
							pop  = 1'b1;
							wr_a = 1'b1;
						end
						K_LOAD_B: begin
							pop  = 1'b1;
							wr_b = 1'b1;
						end
						K_ERR: begin
							pop       = adv;
							err_issue = adv;
						end
						default: begin
							if (adv) begin
								pop     = 1'b1;
								start   = 1'b1;
								state_d = SEQ_RUN;
							end
						end
					endcase
				end
			end
			SEQ_RUN: begin
				if (adv) begin
					issue = 1'b1;
					if (last_i && last_j && last_k) begin
						state_d = SEQ_IDLE;
					end
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) begin
			kind_q <= head.kind;
			nr_q   <= head.nr;
			nc_q   <= head.nc;
			nk_q   <= head.nk;
			i_q    <= '0;
			j_q    <= '0;
			k_q    <= '0;
		end else if (issue) begin
			if (!last_k) begin
				k_q <= k_q + 1'b1;
			end else begin
				k_q <= '0;
				if (!last_j) begin
					j_q <= j_q + 1'b1;
				end else begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		unique case (kind_q)
			K_MUL: begin
				addr_a = elem_addr(AW'(i_q), AW'(k_q));
				addr_b = elem_addr(AW'(k_q), AW'(j_q));
			end
			K_TR_A, K_TR_B: begin
				addr_a = elem_addr(AW'(j_q), AW'(i_q));
				addr_b = elem_addr(AW'(j_q), AW'(i_q));
			end
			default: begin
				addr_a = elem_addr(AW'(i_q), AW'(j_q));
				addr_b = elem_addr(AW'(i_q), AW'(j_q));
			end
		endcase
	end

	assign waddr = elem_addr(AW'(head.row), AW'(head.col));

	// operand stores
	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[waddr] <= head.value;
		end
		if (adv) begin
			rda_s1 <= mem_a[addr_a];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			mem_b[waddr] <= head.value;
		end
		if (adv) begin
			rdb_s1 <= mem_b[addr_b];
		end
	end

	always_comb begin
		tag_issue.kind    = err_issue ? K_ERR : kind_q;
		tag_issue.err     = err_issue;
		tag_issue.first_k = err_issue || (k_q == '0);
		tag_issue.last_k  = err_issue || last_k;
		tag_issue.last_el = err_issue || (last_i && last_j && last_k);
		tag_issue.row     = err_issue ? '0 : ELEM_W'(i_q);
		tag_issue.col     = err_issue ? '0 : ELEM_W'(j_q);
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= issue || err_issue;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2 && tag_s2.last_k;
		end
	end

	assign sum = tag_s2.first_k ? res_s2 : acc_q + res_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1 <= tag_issue;
			tag_s2 <= tag_s1;
			unique case (tag_s1.kind)
				K_ADD:   res_s2 <= rda_s1 + rdb_s1;
				K_SUB:   res_s2 <= rda_s1 - rdb_s1;
				K_TR_A:  res_s2 <= rda_s1;
				K_TR_B:  res_s2 <= rdb_s1;
				K_MUL:   res_s2 <= VAL_W'(rda_s1 * rdb_s1);
				default: res_s2 <= '0;
			endcase
			if (valid_s2) begin
				acc_q <= sum;
				if (tag_s2.last_k) begin
					out_row_q    <= tag_s2.row;
					out_col_q    <= tag_s2.col;
					out_value_q  <= sum;
					out_status_q <= tag_s2.err;
					out_last_q   <= tag_s2.last_el;
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_value_q, out_col_q, out_row_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

endmodule

@@ sv/small_matrix_engine_top.sv @@
// ----------------------------------------------------------------------------
// small_matrix_engine_top
// Integer matrix add, subtract, transpose and multiply over two stored operands.
// ----------------------------------------------------------------------------
// Commands enter a four-entry queue and run in order. A load is written into
// its operand store as the back end pops it. While the output is not stalled,
// add, subtract and transpose stream one result element per cycle; multiply
// runs one multiply-accumulate per cycle on a single shared unit, rows_a *
// cols_b * cols_a in all (DIM cubed at full size, 512 at DIM 8). Each operation
// passes through dispatch, then read, compute and output registers. A shape
// mismatch returns one result with status set. Never-loaded elements read as unknown values.
// ----------------------------------------------------------------------------
module small_matrix_engine_top #(
	parameter int DIM = sme_pkg::DIM_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [sme_pkg::CMD_W-1:0]      s_tuser,   // command
	input  logic [sme_pkg::DATA_W-1:0]     s_tdata,   // row, col, value, zero pad
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [sme_pkg::DATA_W-1:0]     m_tdata,   // out_row, out_col, out_value, zero pad
	output logic                           m_tuser,   // status
	output logic                           m_tlast,
	input  logic                           cfg_we,
	input  logic [sme_pkg::REG_IDX_W-1:0]  cfg_addr,
	input  logic [sme_pkg::CFG_W-1:0]      cfg_wdata
);
	import sme_pkg::*;

	logic     push, pop, full, empty;
	q_entry_t push_data, head;

	sme_front #(
		.DIM(DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.fifo_full (full),
		.push      (push),
		.push_data (push_data)
	);

	sme_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (head),
		.empty     (empty)
	);

	sme_back #(
		.DIM(DIM)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
